// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define QC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define QC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/qcvt_pkg.sv =====
package qcvt_pkg;

    // Quaternion term codes, also the largest_term output encoding.
    typedef enum logic [1:0] {
        TERM_W = 2'd0,
        TERM_X = 2'd1,
        TERM_Y = 2'd2,
        TERM_Z = 2'd3
    } term_t;

    localparam int unsigned LANES  = 3;
    localparam int unsigned TERM_BITS = 2;

    // Pipeline control shared by every stage.
    typedef struct packed {
        logic adv;
    } pipe_ctrl_t;

endpackage

// ===== sv/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to quaternion (Shepperd), fully pipelined.
// Stages in order: the select stage, SQ = (DATA_WIDTH+FRAC_BITS+2)/2 square root stages,
// NQ = DATA_WIDTH+FRAC_BITS+1 divider stages and the output register.
// Throughput: one word per cycle; the whole pipeline holds while the output word is stalled.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data registers are not reset.
module rotation_matrix_to_quaternion_core
    import qcvt_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DATA_WIDTH-1:0] m11,
    input  logic [DATA_WIDTH-1:0] m12,
    input  logic [DATA_WIDTH-1:0] m13,
    input  logic [DATA_WIDTH-1:0] m21,
    input  logic [DATA_WIDTH-1:0] m22,
    input  logic [DATA_WIDTH-1:0] m23,
    input  logic [DATA_WIDTH-1:0] m31,
    input  logic [DATA_WIDTH-1:0] m32,
    input  logic [DATA_WIDTH-1:0] m33,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] quat_w,
    output logic [DATA_WIDTH-1:0] quat_x,
    output logic [DATA_WIDTH-1:0] quat_y,
    output logic [DATA_WIDTH-1:0] quat_z,
    output logic [1:0]            largest_term,
    output logic                  invalid
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    // Radicand (R << F) is below 2^(W+1+F); round its width up to an even bit count.
    localparam int SQ = (W + F + 2) / 2;
    localparam int NX = 2 * SQ;
    // Magnitude of an element sum or difference, up to 2^W.
    localparam int MW = W + 1;
    localparam int NQ = MW + F;
    // Divisor 4B, with B = root >> 1.
    localparam int BW = SQ - 1;
    localparam int DW = BW + 2;
    localparam int SIDE_W  = TERM_BITS + 1 + LANES + LANES * MW;
    localparam int DSIDE_W = TERM_BITS + 1 + LANES + BW;
    localparam int CW = BW + W;

    pipe_ctrl_t ctrl;

    logic                  sel_valid;
    logic [NX-1:0]         sel_x;
    logic [SIDE_W-1:0]     sel_side;
    logic                  sq_valid;
    logic [SQ-1:0]         root;
    logic [SIDE_W-1:0]     sq_side;
    logic [BW-1:0]         b_val;
    logic                  bad_sq;
    logic [DSIDE_W-1:0]    dside;
    logic                  div_valid;
    logic [LANES*NQ-1:0]   quot;
    logic [DSIDE_W-1:0]    div_side;

    logic [BW-1:0]         b_out;
    logic [LANES-1:0]      sgn_out;
    logic                  bad_out;
    term_t                 idx_out;
    logic [W-1:0]          b_sat;
    logic [W-1:0]          lane_sat [LANES];
    logic [W-1:0]          w_next, x_next, y_next, z_next;
    logic [1:0]            term_next;

    logic                  valid_reg;
    logic [W-1:0]          w_reg, x_reg, y_reg, z_reg;
    logic [1:0]            term_reg;
    logic                  invalid_reg;

    // Hold every stage while a finished word waits at the output.
    assign ctrl.adv = !(valid_reg && out_stall);
    assign in_stall = !ctrl.adv;

    // Stage 1: diagonal sums, pick the largest, form radicand and numerators.
    qcvt_select #(
        .W      (W),
        .F      (F),
        .NX     (NX),
        .MW     (MW),
        .SIDE_W (SIDE_W)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (in_valid),
        .m11       (m11),
        .m12       (m12),
        .m13       (m13),
        .m21       (m21),
        .m22       (m22),
        .m23       (m23),
        .m31       (m31),
        .m32       (m32),
        .m33       (m33),
        .sel_valid (sel_valid),
        .sel_x     (sel_x),
        .sel_side  (sel_side)
    );

    // Stages 2 .. SQ+1: integer square root of R << F.
    qcvt_sqrt #(
        .SQ     (SQ),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_valid (sel_valid),
        .x        (sel_x),
        .side     (sel_side),
        .sq_valid (sq_valid),
        .root     (root),
        .sq_side  (sq_side)
    );

    // B = root / 2; a zero B marks the word invalid like a non-positive radicand.
    assign b_val  = root[SQ-1:1];
    assign bad_sq = sq_side[SIDE_W-TERM_BITS-1] || (b_val == '0);
    assign dside  = {sq_side[SIDE_W-1 -: TERM_BITS], bad_sq,
                     sq_side[LANES*MW +: LANES], b_val};

    // Next NQ stages: the three off-diagonal terms, |D| << F divided by 4B.
    qcvt_div #(
        .MW     (MW),
        .F      (F),
        .DW     (DW),
        .SIDE_W (DSIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (sq_valid),
        .den       ({b_val, 2'b00}),
        .mags      (sq_side[LANES*MW-1:0]),
        .side      (dside),
        .div_valid (div_valid),
        .quot      (quot),
        .div_side  (div_side)
    );

    assign b_out   = div_side[BW-1:0];
    assign sgn_out = div_side[BW +: LANES];
    assign bad_out = div_side[BW+LANES];
    assign idx_out = term_t'(div_side[DSIDE_W-1 -: TERM_BITS]);

    // Saturate B and the signed quotients to the output range.
    assign b_sat = (CW'(b_out) > CW'({(W-1){1'b1}})) ? {1'b0, {(W-1){1'b1}}} : W'(b_out);

    for (genvar k = 0; k < LANES; k++)
    begin : g_sat
        logic [NQ-1:0] qmag;
        assign qmag = quot[k*NQ +: NQ];
        always_comb
        begin
            if (!sgn_out[k])
                lane_sat[k] = (qmag > NQ'({(W-1){1'b1}})) ? {1'b0, {(W-1){1'b1}}}
                                                          : qmag[W-1:0];
            else
                lane_sat[k] = (qmag > (NQ'(1) << (W-1))) ? {1'b1, {(W-1){1'b0}}}
                                                          : W'(-qmag[W-1:0]);
        end
    end

    // Put B at the largest term and the quotients at the rest, in w, x, y, z order.
    always_comb
    begin
        w_next    = '0;
        x_next    = '0;
        y_next    = '0;
        z_next    = '0;
        term_next = TERM_W;
        if (!bad_out)
        begin
            term_next = idx_out;
            case (idx_out)
                TERM_W:
                begin
                    w_next = b_sat;       x_next = lane_sat[0];
                    y_next = lane_sat[1]; z_next = lane_sat[2];
                end
                TERM_X:
                begin
                    w_next = lane_sat[0]; x_next = b_sat;
                    y_next = lane_sat[1]; z_next = lane_sat[2];
                end
                TERM_Y:
                begin
                    w_next = lane_sat[0]; x_next = lane_sat[1];
                    y_next = b_sat;       z_next = lane_sat[2];
                end
                default:
                begin
                    w_next = lane_sat[0]; x_next = lane_sat[1];
                    y_next = lane_sat[2]; z_next = b_sat;
                end
            endcase
        end
    end

    // Output register: hold the word until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.adv)
            valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            w_reg       <= w_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            term_reg    <= term_next;
            invalid_reg <= bad_out;
        end
    end

    assign out_valid    = valid_reg;
    assign quat_w       = w_reg;
    assign quat_x       = x_reg;
    assign quat_y       = y_reg;
    assign quat_z       = z_reg;
    assign largest_term = term_reg;
    assign invalid      = invalid_reg;

endmodule

// ===== sv/qcvt_select.sv =====
module qcvt_select
    import qcvt_pkg::*;
#(
    parameter int W  = 16,
    parameter int F  = 14,
    parameter int NX = 32,
    parameter int MW = 17,
    parameter int SIDE_W = 57
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctrl_t          ctrl,
    input  logic                in_valid,
    input  logic [W-1:0]        m11,
    input  logic [W-1:0]        m12,
    input  logic [W-1:0]        m13,
    input  logic [W-1:0]        m21,
    input  logic [W-1:0]        m22,
    input  logic [W-1:0]        m23,
    input  logic [W-1:0]        m31,
    input  logic [W-1:0]        m32,
    input  logic [W-1:0]        m33,
    output logic                sel_valid,
    output logic [NX-1:0]       sel_x,
    output logic [SIDE_W-1:0]   sel_side
);

    localparam int SW = W + 2;

    logic signed [SW-1:0] e11, e22, e33;
    logic signed [SW-1:0] sum_w, sum_x, sum_y, sum_z, best, rad;
    logic signed [W:0]    dwx, dwy, dwz, sxy, sxz, syz;
    logic signed [W:0]    lane [LANES];
    logic [MW-1:0]        mag [LANES];
    logic [LANES-1:0]     sgn;
    term_t                idx;
    logic                 bad;
    logic [NX-1:0]        x_next;
    logic                 valid_reg;
    logic [NX-1:0]        x_reg;
    logic [SIDE_W-1:0]    side_reg;

    assign e11 = SW'($signed(m11));
    assign e22 = SW'($signed(m22));
    assign e33 = SW'($signed(m33));

    assign sum_w = e11 + e22 + e33;
    assign sum_x = e11 - e22 - e33;
    assign sum_y = e22 - e11 - e33;
    assign sum_z = e33 - e11 - e22;

    // Largest diagonal sum; ties keep the lower term.
    always_comb
    begin
        best = sum_w;
        idx  = TERM_W;
        if (sum_x > best)
        begin
            best = sum_x;
            idx  = TERM_X;
        end
        if (sum_y > best)
        begin
            best = sum_y;
            idx  = TERM_Y;
        end
        if (sum_z > best)
        begin
            best = sum_z;
            idx  = TERM_Z;
        end
    end

    assign rad    = best + (SW'(1) << F);
    assign bad    = rad[SW-1] || (rad == '0);
    assign x_next = bad ? '0 : (NX'(rad[W:0]) << F);

    assign dwx = (W+1)'($signed(m23)) - (W+1)'($signed(m32));
    assign dwy = (W+1)'($signed(m31)) - (W+1)'($signed(m13));
    assign dwz = (W+1)'($signed(m12)) - (W+1)'($signed(m21));
    assign sxy = (W+1)'($signed(m12)) + (W+1)'($signed(m21));
    assign sxz = (W+1)'($signed(m31)) + (W+1)'($signed(m13));
    assign syz = (W+1)'($signed(m23)) + (W+1)'($signed(m32));

    // Route the three off-diagonal numerators in w, x, y, z order, skipping idx.
    always_comb
    begin
        case (idx)
            TERM_W:
            begin
                lane[0] = dwx; lane[1] = dwy; lane[2] = dwz;
            end
            TERM_X:
            begin
                lane[0] = dwx; lane[1] = sxy; lane[2] = sxz;
            end
            TERM_Y:
            begin
                lane[0] = dwy; lane[1] = sxy; lane[2] = syz;
            end
            default:
            begin
                lane[0] = dwz; lane[1] = sxz; lane[2] = syz;
            end
        endcase
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_mag
        assign sgn[k] = lane[k][W];
        assign mag[k] = lane[k][W] ? MW'(-lane[k]) : MW'(lane[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            x_reg    <= x_next;
            side_reg <= {idx, bad, sgn, mag[2], mag[1], mag[0]};
        end
    end

    assign sel_valid = valid_reg;
    assign sel_x     = x_reg;
    assign sel_side  = side_reg;

endmodule

// ===== sv/qcvt_sqrt.sv =====
module qcvt_sqrt
    import qcvt_pkg::*;
#(
    parameter int SQ     = 16,
    parameter int SIDE_W = 57
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctrl_t          ctrl,
    input  logic                in_valid,
    input  logic [2*SQ-1:0]     x,
    input  logic [SIDE_W-1:0]   side,
    output logic                sq_valid,
    output logic [SQ-1:0]       root,
    output logic [SIDE_W-1:0]   sq_side
);

    localparam int NX = 2 * SQ;
    localparam int RW = SQ + 3;

    logic              v_reg    [SQ];
    logic [RW-1:0]     rem_reg  [SQ];
    logic [SQ-1:0]     root_reg [SQ];
    logic [NX-1:0]     x_reg    [SQ];
    logic [SIDE_W-1:0] side_reg [SQ];

    // One root bit per stage: bring down two radicand bits, try 4r+1.
    for (genvar s = 0; s < SQ; s++)
    begin : g_stage
        logic              v_in;
        logic [RW-1:0]     rem_in, rem_sh, trial, rem_next;
        logic [SQ-1:0]     root_in, root_next;
        logic [NX-1:0]     x_in;
        logic [SIDE_W-1:0] side_in;
        logic              ge;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x;
            assign side_in = side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign rem_sh    = {rem_in[RW-3:0], x_in[NX-1 -: 2]};
        assign trial     = {1'b0, root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[SQ-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (ctrl.adv)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.adv)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                x_reg[s]    <= x_in << 2;
                side_reg[s] <= side_in;
            end
        end
    end

    assign sq_valid = v_reg[SQ-1];
    assign root     = root_reg[SQ-1];
    assign sq_side  = side_reg[SQ-1];

endmodule

// ===== sv/qcvt_div.sv =====
module qcvt_div
    import qcvt_pkg::*;
#(
    parameter int MW     = 17,
    parameter int F      = 14,
    parameter int DW     = 17,
    parameter int SIDE_W = 21
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pipe_ctrl_t            ctrl,
    input  logic                  in_valid,
    input  logic [DW-1:0]         den,
    input  logic [LANES*MW-1:0]   mags,
    input  logic [SIDE_W-1:0]     side,
    output logic                  div_valid,
    output logic [LANES*(MW+F)-1:0] quot,
    output logic [SIDE_W-1:0]     div_side
);

    localparam int NQ = MW + F;

    logic              v_reg    [NQ];
    logic [DW-1:0]     den_reg  [NQ];
    logic [SIDE_W-1:0] side_reg [NQ];
    logic [DW-1:0]     rem_reg  [NQ][LANES];
    logic [NQ-1:0]     num_reg  [NQ][LANES];
    logic [NQ-1:0]     q_reg    [NQ][LANES];

    // Restoring division, one quotient bit per stage, three lanes on one divisor.
    for (genvar s = 0; s < NQ; s++)
    begin : g_stage
        logic              v_in;
        logic [DW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign den_in  = den;
            assign side_in = side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (ctrl.adv)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.adv)
            begin
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end

        for (genvar k = 0; k < LANES; k++)
        begin : g_lane
            logic [DW-1:0] rem_in;
            logic [NQ-1:0] num_in, q_in;
            logic [DW:0]   rem_sh, rem_sub;
            logic          ge;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = NQ'(mags[k*MW +: MW]) << F;
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1][k];
                assign num_in = num_reg[s-1][k];
                assign q_in   = q_reg[s-1][k];
            end

            assign rem_sh  = {rem_in, num_in[NQ-1]};
            assign ge      = (rem_sh >= {1'b0, den_in});
            assign rem_sub = rem_sh - {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (ctrl.adv)
                begin
                    rem_reg[s][k] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                    num_reg[s][k] <= num_in << 1;
                    q_reg[s][k]   <= {q_in[NQ-2:0], ge};
                end
            end
        end
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_out
        assign quot[k*NQ +: NQ] = q_reg[NQ-1][k];
    end

    assign div_valid = v_reg[NQ-1];
    assign div_side  = side_reg[NQ-1];

endmodule

// ===== sv/qcvt_checker.sv =====
`include "assert_macros.svh"

module qcvt_checker
    import qcvt_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [DATA_WIDTH-1:0] quat_w,
    input logic [DATA_WIDTH-1:0] quat_x,
    input logic [DATA_WIDTH-1:0] quat_y,
    input logic [DATA_WIDTH-1:0] quat_z,
    input logic [1:0]            largest_term,
    input logic                  invalid
);

    localparam int S = DATA_WIDTH - 1;

    `QC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid during reset")

    `QC_ASSERT(a_invalid_zero, clk, rst_n, out_valid && invalid |-> quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0 && largest_term == TERM_W, "invalid word not cleared")

    `QC_ASSERT(a_largest_nonneg, clk, rst_n, out_valid && !invalid |-> (largest_term == TERM_W && !quat_w[S]) || (largest_term == TERM_X && !quat_x[S]) || (largest_term == TERM_Y && !quat_y[S]) || (largest_term == TERM_Z && !quat_z[S]), "largest term negative")

    `QC_ASSERT(a_idle_no_stall, clk, rst_n, !out_valid |-> !in_stall, "input stalled with empty output")

    `QC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(quat_w) && $stable(quat_x) && $stable(quat_y) && $stable(quat_z) && $stable(largest_term) && $stable(invalid), "stalled word changed")

endmodule

bind rotation_matrix_to_quaternion_core qcvt_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qcvt_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import qcvt_pkg::*;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int LATENCY = 49;
    localparam int RANDOM_WORDS = 1800;
    localparam int HANG_LIMIT = 20000;
    localparam int ONE = 1 << FB;

    typedef struct packed {
        logic [DW-1:0] w;
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] z;
        term_t         term;
        logic          bad;
    } quat_t;

    typedef struct {
        logic [DW-1:0] m[9];
        logic          known;   // expected value typed in below
        quat_t         q;
    } matrix_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DW-1:0] m11 = '0, m12 = '0, m13 = '0;
    logic [DW-1:0] m21 = '0, m22 = '0, m23 = '0;
    logic [DW-1:0] m31 = '0, m32 = '0, m33 = '0;
    logic [DW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic [1:0] largest_term;
    logic invalid;

    quat_t expected_quats[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;
    bit long_hold = 1'b0;

    rotation_matrix_to_quaternion_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .m11(m11), .m12(m12), .m13(m13),
        .m21(m21), .m22(m22), .m23(m23),
        .m31(m31), .m32(m32), .m33(m33),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .largest_term(largest_term), .invalid(invalid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bit-by-bit integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic longint clamp(longint v);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Divide by 4B in Q format, truncating toward zero.
    function automatic longint quarter_div(longint d, longint unsigned den);
        longint unsigned mag;
        longint r;
        mag = (d < 0) ? longint'(-d) : d;
        r = longint'((mag << FB) / den);
        return (d < 0) ? -r : r;
    endfunction

    function automatic quat_t shepperd(logic [DW-1:0] mm[9]);
        longint e[9];
        longint s[4];
        longint q[4];
        longint best, rad;
        longint unsigned b, den;
        int idx;
        quat_t r;
        for (int i = 0; i < 9; i++)
            e[i] = longint'($signed(mm[i]));
        s[0] = e[0] + e[4] + e[8];
        s[1] = e[0] - e[4] - e[8];
        s[2] = e[4] - e[0] - e[8];
        s[3] = e[8] - e[0] - e[4];
        best = s[0];
        idx = 0;
        for (int k = 1; k < 4; k++)
            if (s[k] > best)
            begin
                best = s[k];
                idx = k;
            end
        q = '{0, 0, 0, 0};
        rad = best + ONE;
        b = (rad > 0) ? int_sqrt(longint'(rad) << FB) >> 1 : 0;
        if (b == 0)
            idx = 0;
        else
        begin
            den = b << 2;
            q[idx] = b;
            case (idx)
                0: begin
                    q[1] = quarter_div(e[5] - e[7], den);
                    q[2] = quarter_div(e[6] - e[2], den);
                    q[3] = quarter_div(e[1] - e[3], den);
                end
                1: begin
                    q[0] = quarter_div(e[5] - e[7], den);
                    q[2] = quarter_div(e[1] + e[3], den);
                    q[3] = quarter_div(e[6] + e[2], den);
                end
                2: begin
                    q[0] = quarter_div(e[6] - e[2], den);
                    q[1] = quarter_div(e[1] + e[3], den);
                    q[3] = quarter_div(e[5] + e[7], den);
                end
                default: begin
                    q[0] = quarter_div(e[1] - e[3], den);
                    q[1] = quarter_div(e[6] + e[2], den);
                    q[2] = quarter_div(e[5] + e[7], den);
                end
            endcase
        end
        r.w = DW'(clamp(q[0]));
        r.x = DW'(clamp(q[1]));
        r.y = DW'(clamp(q[2]));
        r.z = DW'(clamp(q[3]));
        r.term = term_t'(idx);
        r.bad = (b == 0);
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // Offer one word and hold it until accepted; predict it at acceptance.
    task automatic send_word(logic [DW-1:0] mm[9], bit known, quat_t q);
        m11 <= mm[0]; m12 <= mm[1]; m13 <= mm[2];
        m21 <= mm[3]; m22 <= mm[4]; m23 <= mm[5];
        m31 <= mm[6]; m32 <= mm[7]; m33 <= mm[8];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_quats.push_back(known ? q : shepperd(mm));
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // Directed table: extremes, each winning term and ties.
    matrix_row_t directed[$];

    task automatic add_row(int a, int b, int c, int d, int e, int f, int g, int h, int i,
                           bit known = 0, quat_t q = '0);
        matrix_row_t r;
        r.m = '{a[DW-1:0], b[DW-1:0], c[DW-1:0], d[DW-1:0], e[DW-1:0],
                f[DW-1:0], g[DW-1:0], h[DW-1:0], i[DW-1:0]};
        r.known = known;
        r.q = q;
        directed.push_back(r);
    endtask

    // Random matrix: mostly entries within +-1.0, some raw noise, some all-extreme entries.
    function automatic void rand_matrix(output logic [DW-1:0] mm[9]);
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
        begin
            if (mode < 6)
                mm[i] = DW'($urandom_range(0, 2 * ONE) - ONE);
            else if (mode < 9)
                mm[i] = DW'($urandom);
            else
                mm[i] = ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
        end
        // Bias one diagonal entry (m11, m22 or m33) near one to favor the x, y or z term.
        if (mode < 4)
            mm[mode * 4 % 12] = DW'(ONE - $urandom_range(0, 2000));
    endfunction

    // Stimulus: directed table then random words.
    initial
    begin
        logic [DW-1:0] mm[9];
        int gap;
        add_row(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1,
                '{w: 16'(ONE), x: 0, y: 0, z: 0, term: TERM_W, bad: 0});
        add_row(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 1,
                '{w: 0, x: 16'(ONE), y: 0, z: 0, term: TERM_X, bad: 0});
        add_row(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE, 1,
                '{w: 0, x: 0, y: 16'(ONE), z: 0, term: TERM_Y, bad: 0});
        add_row(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 1,
                '{w: 0, x: 0, y: 0, z: 16'(ONE), term: TERM_Z, bad: 0});
        // All zero: every sum ties, w wins.
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                '{w: 16'(ONE / 2), x: 0, y: 0, z: 0, term: TERM_W, bad: 0});
        // Diagonal at its minimum: the three axis sums tie high, x wins.
        add_row(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 0);
        // Diagonal sum exactly -1.0, so the w radicand would be zero; an axis term wins.
        add_row(-ONE / 3, 0, 0, 0, -ONE / 3, 0, 0, 0, -ONE / 3 - 1, 0);
        add_row(-ONE / 3 - 1, 0, 0, 0, -ONE / 3, 0, 0, 0, -ONE / 3, 0);
        // Diagonal sum one LSB above -1.0; the three axis sums tie and x wins.
        add_row(-5461, 0, 0, 0, -5461, 0, 0, 0, -5461, 0);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
        add_row(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768, 0);
        add_row(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768, 0);
        add_row(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767, 0);
        add_row(-8000, 1000, -2000, 3000, -8000, -4000, 5000, 6000, -8000, 0);
        add_row(100, 200, 300, 400, 100, 600, 700, 800, 100, 0);
        add_row(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                16'sh5555, 16'shAAAA, 16'sh5555, 0);
        add_row(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                16'shAAAA, 16'sh5555, 16'shAAAA, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_word(directed[i].m, directed[i].known, directed[i].q);
            gap = pick_gap();
            if (gap > 0)
            begin
                drop_valid();
                repeat (gap) @(posedge clk);
            end
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            rand_matrix(mm);
            send_word(mm, 1'b0, '0);
            // Run a back-to-back stretch in the middle, without gaps.
            gap = (n > 600 && n < 900) ? 0 : pick_gap();
            if (gap > 0)
            begin
                drop_valid();
                repeat (gap) @(posedge clk);
            end
        end
        drop_valid();
        stim_done = 1'b1;
    end

    // Receiver stall: random gaps, plus one long hold-off to back up the pipeline.
    initial
    begin
        int gap;
        wait (rst_n);
        repeat (300) @(posedge clk);
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b1;
        forever
        begin
            // Stall at random while words are expected; otherwise release the stall.
            if (expected_quats.size() > 0 && $urandom_range(0, 2) == 0)
            begin
                gap = pick_gap();
                out_stall <= 1'b1;
                repeat (gap + 1) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Compare each accepted word with the oldest prediction.
    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_quats.size() == 0)
            begin
                $display("%0t: unexpected word w=%h x=%h y=%h z=%h", $time,
                         quat_w, quat_x, quat_y, quat_z);
                errors++;
            end
            else
            begin
                want = expected_quats.pop_front();
                if (quat_w !== want.w || quat_x !== want.x || quat_y !== want.y ||
                    quat_z !== want.z || largest_term !== want.term ||
                    invalid !== want.bad)
                begin
                    $display("%0t: mismatch expected w=%h x=%h y=%h z=%h term=%0d inv=%b",
                             $time, want.w, want.x, want.y, want.z, want.term, want.bad);
                    $display("%0t:           actual w=%h x=%h y=%h z=%h term=%0d inv=%b",
                             $time, quat_w, quat_x, quat_y, quat_z, largest_term, invalid);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > HANG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drain: wait for every prediction to be met, then let the pipeline settle.
    initial
    begin
        wait (stim_done && long_hold && expected_quats.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_quats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/qcvt_pkg.sv
sv/qcvt_select.sv
sv/qcvt_sqrt.sv
sv/qcvt_div.sv
sv/rotation_matrix_to_quaternion_core.sv
sv/qcvt_checker.sv
tb/sv/testbench.sv
